// ===== src/i2cts_pkg.sv =====
package i2cts_pkg;

  typedef enum logic [1:0] {
    OP_STATUS  = 2'd0,
    OP_MASTER  = 2'd1,
    OP_LISTEN  = 2'd2,
    OP_RESPOND = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ACT_START   = 4'd0,
    ACT_ADDRESS = 4'd1,
    ACT_SEND    = 4'd2,
    ACT_STORE   = 4'd3,
    ACT_ACK     = 4'd4,
    ACT_NACK    = 4'd5,
    ACT_STOP    = 4'd6,
    ACT_RELEASE = 4'd7,
    ACT_LISTEN  = 4'd8,
    ACT_ENABLE  = 4'd9,
    ACT_BLOCK   = 4'd10,
    ACT_ZERO    = 4'd11
  } action_e;

  // Bus status codes, the status byte shifted right by three.
  localparam logic [4:0] ST_START          = 5'd1;
  localparam logic [4:0] ST_RSTART         = 5'd2;
  localparam logic [4:0] ST_MT_SLA_ACK     = 5'd3;
  localparam logic [4:0] ST_MT_SLA_NACK    = 5'd4;
  localparam logic [4:0] ST_MT_DATA_ACK    = 5'd5;
  localparam logic [4:0] ST_MT_DATA_NACK   = 5'd6;
  localparam logic [4:0] ST_ARB_LOST       = 5'd7;
  localparam logic [4:0] ST_MR_SLA_ACK     = 5'd8;
  localparam logic [4:0] ST_MR_SLA_NACK    = 5'd9;
  localparam logic [4:0] ST_MR_DATA_ACK    = 5'd10;
  localparam logic [4:0] ST_MR_DATA_NACK   = 5'd11;
  localparam logic [4:0] ST_SR_SLA_ACK     = 5'd12;
  localparam logic [4:0] ST_SR_ARB_SLA     = 5'd13;
  localparam logic [4:0] ST_SR_GC_ACK      = 5'd14;
  localparam logic [4:0] ST_SR_ARB_GC      = 5'd15;
  localparam logic [4:0] ST_SR_DATA_ACK    = 5'd16;
  localparam logic [4:0] ST_SR_DATA_NACK   = 5'd17;
  localparam logic [4:0] ST_SR_GC_DATA_ACK = 5'd18;
  localparam logic [4:0] ST_SR_GC_DATA_NAK = 5'd19;
  localparam logic [4:0] ST_SR_STOP        = 5'd20;
  localparam logic [4:0] ST_ST_SLA_ACK     = 5'd21;
  localparam logic [4:0] ST_ST_ARB_SLA     = 5'd22;
  localparam logic [4:0] ST_ST_DATA_ACK    = 5'd23;
  localparam logic [4:0] ST_ST_DATA_NACK   = 5'd24;
  localparam logic [4:0] ST_ST_LAST_ACK    = 5'd25;

  localparam logic [1:0] SEL_MASTER_TX = 2'd0;
  localparam logic [1:0] SEL_MASTER_RX = 2'd1;
  localparam logic [1:0] SEL_SLAVE_RX  = 2'd2;
  localparam logic [1:0] SEL_SLAVE_TX  = 2'd3;

  localparam logic [5:0] ERR_SUCCESS = 6'h00;
  localparam logic [5:0] ERR_GENERIC = 6'h20;

  localparam int unsigned RunMax = 3;

  typedef struct packed {
    opcode_e    opcode;
    logic [4:0] status_code;
    logic [7:0] tx_length;
    logic [7:0] rx_length;
    logic [7:0] target_address;
    logic       lines_idle;
  } req_t;

  typedef struct packed {
    action_e    act;
    logic [7:0] data;
    logic [1:0] sel;
    logic [7:0] idx;
  } entry_t;

  typedef struct packed {
    logic [5:0] err;
    logic       busy;
    logic       mdone;
    logic       sdone;
  } flags_t;

  typedef struct packed {
    entry_t [RunMax-1:0] ent;
    logic   [1:0]        count;
    flags_t              flags;
  } run_t;

  typedef struct packed {
    logic       rmode;
    logic       busy;
    logic [7:0] addr;
    logic [7:0] mpos;
    logic [7:0] spos;
    logic [7:0] msc;
    logic [7:0] mrc;
    logic [7:0] src;
    logic [7:0] ssc;
    logic [5:0] err;
  } state_t;

  function automatic entry_t mk_ent(action_e act, logic [7:0] data, logic [1:0] sel,
                                    logic [7:0] idx);
    entry_t e;
    e.act  = act;
    e.data = data;
    e.sel  = sel;
    e.idx  = idx;
    return e;
  endfunction

endpackage

// ===== src/i2cts_ctrl.sv =====
module i2cts_ctrl import i2cts_pkg::*; #(
  parameter int unsigned MaxLength = 255
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  req_t req_i,
  output run_t run_o
);

  localparam int unsigned CapInt = (MaxLength > 255) ? 255 : MaxLength;
  localparam logic [7:0]  LenCap = 8'(CapInt);

  state_t     s_q, s_d;
  entry_t     ent [RunMax];
  logic [1:0] n;
  logic       mdone, sdone;
  logic [7:0] txl, rxl;

  assign txl = (req_i.tx_length > LenCap) ? LenCap : req_i.tx_length;
  assign rxl = (req_i.rx_length > LenCap) ? LenCap : req_i.rx_length;

  always_comb begin
    s_d   = s_q;
    n     = 2'd0;
    mdone = 1'b0;
    sdone = 1'b0;
    for (int k = 0; k < RunMax; k++) begin
      ent[k] = mk_ent(ACT_START, 8'd0, 2'd0, 8'd0);
    end
    unique case (req_i.opcode)
      OP_STATUS: begin
        case (req_i.status_code) inside
          ST_START, ST_RSTART: begin
            s_d.mpos = 8'd0;
            s_d.busy = 1'b1;
            ent[n] = mk_ent(ACT_ADDRESS, {s_d.addr[7:1], s_d.rmode}, 2'd0, 8'd0);
            n = n + 2'd1;
          end
          ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
            if (s_d.mpos < s_d.msc) begin
              ent[n] = mk_ent(ACT_SEND, 8'd0, SEL_MASTER_TX, s_d.mpos);
              n = n + 2'd1;
              s_d.mpos = s_d.mpos + 8'd1;
            end else if (s_d.mrc != 8'd0) begin
              s_d.rmode = 1'b1;
              ent[n] = mk_ent(ACT_START, 8'd0, 2'd0, 8'd0);
              n = n + 2'd1;
              s_d.msc = 8'd0;
            end else begin
              s_d.err  = ERR_SUCCESS;
              ent[n] = mk_ent(ACT_STOP, 8'd0, 2'd0, 8'd0);
              n = n + 2'd1;
              s_d.busy = 1'b0;
              s_d.msc  = 8'd0;
              s_d.mrc  = 8'd0;
              mdone    = 1'b1;
              if (s_d.src != 8'd0) begin
                ent[n] = mk_ent(ACT_LISTEN, 8'd0, 2'd0, 8'd0);
                n = n + 2'd1;
              end
            end
          end
          ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_ARB_LOST, ST_MR_SLA_NACK: begin
            s_d.err = {1'b0, req_i.status_code};
            ent[n] = mk_ent((req_i.status_code == ST_ARB_LOST) ? ACT_RELEASE : ACT_STOP,
                            8'd0, 2'd0, 8'd0);
            n = n + 2'd1;
            s_d.busy = 1'b0;
            ent[n] = mk_ent((s_d.src != 8'd0) ? ACT_LISTEN : ACT_ENABLE, 8'd0, 2'd0, 8'd0);
            n = n + 2'd1;
            s_d.msc = 8'd0;
            s_d.mrc = 8'd0;
            mdone   = 1'b1;
          end
          ST_MR_SLA_ACK, ST_MR_DATA_ACK: begin
            if (req_i.status_code == ST_MR_DATA_ACK && s_d.mpos < s_d.mrc) begin
              ent[n] = mk_ent(ACT_STORE, 8'd0, SEL_MASTER_RX, s_d.mpos);
              n = n + 2'd1;
              s_d.mpos = s_d.mpos + 8'd1;
            end
            ent[n] = mk_ent((({1'b0, s_d.mpos} + 9'd1) < {1'b0, s_d.mrc}) ? ACT_ACK : ACT_NACK,
                            8'd0, 2'd0, 8'd0);
            n = n + 2'd1;
          end
          ST_MR_DATA_NACK: begin
            if (s_d.mpos < s_d.mrc) begin
              ent[n] = mk_ent(ACT_STORE, 8'd0, SEL_MASTER_RX, s_d.mpos);
              n = n + 2'd1;
            end
            s_d.err = {1'b0, req_i.status_code};
            ent[n] = mk_ent(ACT_STOP, 8'd0, 2'd0, 8'd0);
            n = n + 2'd1;
            s_d.busy = 1'b0;
            ent[n] = mk_ent((s_d.src != 8'd0) ? ACT_LISTEN : ACT_ENABLE, 8'd0, 2'd0, 8'd0);
            n = n + 2'd1;
            s_d.msc = 8'd0;
            s_d.mrc = 8'd0;
            mdone   = 1'b1;
          end
          ST_SR_SLA_ACK, ST_SR_ARB_SLA, ST_SR_GC_ACK, ST_SR_ARB_GC: begin
            if (s_d.src != 8'd0) begin
              s_d.spos = 8'd0;
              s_d.busy = 1'b1;
              ent[n] = mk_ent(ACT_ACK, 8'd0, 2'd0, 8'd0);
            end else begin
              s_d.err = {1'b0, req_i.status_code};
              ent[n] = mk_ent(ACT_NACK, 8'd0, 2'd0, 8'd0);
            end
            n = n + 2'd1;
          end
          ST_SR_DATA_ACK, ST_SR_DATA_NACK, ST_SR_GC_DATA_ACK, ST_SR_GC_DATA_NAK: begin
            if ((req_i.status_code == ST_SR_DATA_ACK ||
                 req_i.status_code == ST_SR_GC_DATA_ACK) && s_d.spos < s_d.src) begin
              ent[n] = mk_ent(ACT_STORE, 8'd0, SEL_SLAVE_RX, s_d.spos);
              n = n + 2'd1;
              ent[n] = mk_ent((({1'b0, s_d.spos} + 9'd1) < {1'b0, s_d.src}) ?
                              ACT_ACK : ACT_NACK, 8'd0, 2'd0, 8'd0);
              n = n + 2'd1;
              s_d.spos = s_d.spos + 8'd1;
            end else begin
              // A pending master request takes the bus once the slave side lets go.
              ent[n] = mk_ent((s_d.msc != 8'd0 || s_d.mrc != 8'd0) ? ACT_START : ACT_NACK,
                              8'd0, 2'd0, 8'd0);
              n = n + 2'd1;
            end
          end
          ST_SR_STOP: begin
            s_d.err  = {1'b0, ST_SR_STOP};
            s_d.busy = 1'b0;
            ent[n] = mk_ent(ACT_BLOCK, 8'd0, SEL_SLAVE_RX, s_d.spos);
            n = n + 2'd1;
            s_d.src = 8'd0;
            sdone   = 1'b1;
          end
          ST_ST_SLA_ACK, ST_ST_ARB_SLA, ST_ST_DATA_ACK: begin
            if (req_i.status_code != ST_ST_DATA_ACK) begin
              s_d.spos = 8'd0;
              s_d.busy = 1'b1;
            end
            if (s_d.spos < s_d.ssc) begin
              ent[n] = mk_ent(ACT_SEND, 8'd0, SEL_SLAVE_TX, s_d.spos);
              n = n + 2'd1;
              ent[n] = mk_ent((({1'b0, s_d.spos} + 9'd1) < {1'b0, s_d.ssc}) ?
                              ACT_ACK : ACT_NACK, 8'd0, 2'd0, 8'd0);
              n = n + 2'd1;
              s_d.spos = s_d.spos + 8'd1;
            end else begin
              ent[n] = mk_ent(ACT_ZERO, 8'd0, 2'd0, 8'd0);
              n = n + 2'd1;
              ent[n] = mk_ent(ACT_NACK, 8'd0, 2'd0, 8'd0);
              n = n + 2'd1;
            end
          end
          ST_ST_DATA_NACK, ST_ST_LAST_ACK: begin
            ent[n] = mk_ent(ACT_ENABLE, 8'd0, 2'd0, 8'd0);
            n = n + 2'd1;
            s_d.err  = {1'b0, req_i.status_code};
            s_d.busy = 1'b0;
            s_d.ssc  = 8'd0;
            sdone    = 1'b1;
            if (s_d.msc != 8'd0 || s_d.mrc != 8'd0) begin
              ent[n] = mk_ent(ACT_START, 8'd0, 2'd0, 8'd0);
              n = n + 2'd1;
            end
          end
          default: begin
            // Bus error, no-information status or a code the core never reports.
            s_d.err  = ERR_GENERIC;
            s_d.spos = 8'd0;
            s_d.mpos = 8'd0;
            s_d.msc  = 8'd0;
            s_d.mrc  = 8'd0;
            s_d.src  = 8'd0;
            s_d.ssc  = 8'd0;
            ent[n] = mk_ent(ACT_RELEASE, 8'd0, 2'd0, 8'd0);
            n = n + 2'd1;
            s_d.busy = 1'b0;
            mdone    = 1'b1;
            sdone    = 1'b1;
          end
        endcase
      end
      OP_MASTER: begin
        if (txl == 8'd0 && rxl == 8'd0) begin
          s_d.msc = 8'd0;
          s_d.mrc = 8'd0;
        end else begin
          s_d.msc   = txl;
          s_d.mrc   = rxl;
          s_d.addr  = req_i.target_address;
          s_d.rmode = (txl == 8'd0);
          if (!s_q.busy && req_i.lines_idle) begin
            ent[n] = mk_ent(ACT_START, 8'd0, 2'd0, 8'd0);
            n = n + 2'd1;
          end
        end
      end
      OP_LISTEN: begin
        s_d.src = rxl;
        if (!s_q.busy) begin
          ent[n] = mk_ent(((s_q.msc != 8'd0 || s_q.mrc != 8'd0) && req_i.lines_idle) ?
                          ACT_START : ACT_LISTEN, 8'd0, 2'd0, 8'd0);
          n = n + 2'd1;
        end
      end
      OP_RESPOND: begin
        if (txl != 8'd0) begin
          s_d.spos = 8'd0;
          s_d.ssc  = txl;
          ent[n] = mk_ent(ACT_LISTEN, 8'd0, 2'd0, 8'd0);
        end else if (s_q.msc != 8'd0 || s_q.mrc != 8'd0) begin
          ent[n] = mk_ent(ACT_START, 8'd0, 2'd0, 8'd0);
        end else begin
          s_d.busy = 1'b0;
          ent[n] = mk_ent(ACT_ENABLE, 8'd0, 2'd0, 8'd0);
        end
        n = n + 2'd1;
      end
      default: begin
        s_d = s_q;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < RunMax; k++) begin
      run_o.ent[k] = ent[k];
    end
    run_o.count       = n;
    run_o.flags.err   = s_d.err;
    run_o.flags.busy  = s_d.busy;
    run_o.flags.mdone = mdone;
    run_o.flags.sdone = sdone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else if (accept_i) begin
      s_q <= s_d;
    end
  end

endmodule

// ===== src/i2cts_run_buf.sv =====
module i2cts_run_buf import i2cts_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  run_t   run_i,
  output logic   ready_o,
  output logic   valid_o,
  input  logic   ready_i,
  output entry_t head_o,
  output flags_t flags_o,
  output logic   last_o
);

  entry_t [RunMax-1:0] ent_q, ent_d;
  flags_t              flags_q;
  logic   [1:0]        cnt_q, cnt_d;
  logic                pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  // A new request may load once the run held here is gone or leaves this cycle.
  assign ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && ready_i);
  assign head_o  = ent_q[0];
  assign flags_o = flags_q;
  assign last_o  = (cnt_q == 2'd1);

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (push_i) begin
      ent_d = run_i.ent;
      cnt_d = run_i.count;
    end else if (pop) begin
      for (int k = 0; k < RunMax - 1; k++) begin
        ent_d[k] = ent_q[k+1];
      end
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (push_i) begin
      flags_q <= run_i.flags;
    end
  end

  a_push_only_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && ready_i)))
    else $error("run loaded over undelivered results");

  a_pop_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("result count did not step down on delivery");

  a_load_shows_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && run_i.count != 2'd0) |=>
      (valid_o && head_o == $past(run_i.ent[0]) && cnt_q == $past(run_i.count)))
    else $error("first action of a run not presented");

endmodule

// ===== src/i2c_transaction_sequencer_top.sv =====
// Two-wire transaction sequencer above a byte-level bus core.
// Request channel: in_valid_i/in_ready_o carry one request (opcode, status
// code, lengths, target address, line state). Result channel:
// out_valid_o/out_ready_i carry one action for the byte core at a time.
// A request produces a run of zero to three actions; last_o marks the final
// action of a run and the flag and error fields are equal across a run.
// The sequencer state is updated in the cycle a request is taken, and the
// run is loaded into the output register, so the first action appears in the
// cycle after acceptance. Actions leave one per cycle from that register
// while the receiver is ready. A request waits for the run before it: the next
// request is taken in the cycle the last action of the current run is
// delivered, or at once when the output register is empty.
// When the receiver stalls, the held action stays on the port and requests
// wait until the run has drained to its final action being taken.
// Reset clears all sequencer state (lengths, positions, busy, mode, error)
// and empties the output register; no clearing pass is needed.
module i2c_transaction_sequencer_top import i2cts_pkg::*; #(
  parameter int unsigned MaxLength = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [4:0] status_code_i,
  input  logic [7:0] tx_length_i,
  input  logic [7:0] rx_length_i,
  input  logic [7:0] target_address_i,
  input  logic       lines_idle_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] action_o,
  output logic [7:0] data_byte_o,
  output logic [1:0] buffer_select_o,
  output logic [7:0] buffer_index_o,
  output logic [4:0] error_status_o,
  output logic       error_generic_o,
  output logic       busy_flag_o,
  output logic       master_done_o,
  output logic       slave_done_o,
  output logic       last_o
);

  req_t   req;
  run_t   run;
  entry_t head;
  flags_t flags;
  logic   accept;

  assign req.opcode         = opcode_e'(opcode_i);
  assign req.status_code    = status_code_i;
  assign req.tx_length      = tx_length_i;
  assign req.rx_length      = rx_length_i;
  assign req.target_address = target_address_i;
  assign req.lines_idle     = lines_idle_i;

  assign accept = in_valid_i && in_ready_o;

  i2cts_ctrl #(
    .MaxLength(MaxLength)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req),
    .run_o    (run)
  );

  i2cts_run_buf u_run_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .run_i   (run),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head),
    .flags_o (flags),
    .last_o  (last_o)
  );

  assign action_o        = head.act;
  assign data_byte_o     = head.data;
  assign buffer_select_o = head.sel;
  assign buffer_index_o  = head.idx;
  assign error_status_o  = flags.err[4:0];
  assign error_generic_o = flags.err[5];
  assign busy_flag_o     = flags.busy;
  assign master_done_o   = flags.mdone;
  assign slave_done_o    = flags.sdone;

endmodule

// ===== tb/sv/tb_i2c_transaction_sequencer_top.sv =====
module tb_i2c_transaction_sequencer_top;
  import i2cts_pkg::*;

  // Status codes outside the named set: bus error and "no information".
  localparam logic [4:0] ST_BUS_ERROR = 5'd0;
  localparam logic [4:0] ST_NO_INFO   = 5'd31;
  localparam logic [1:0] SEL_UNUSED   = 2'd0;

  localparam int unsigned RandomRequests    = 420;
  localparam int unsigned CycleLimit        = 500000;
  localparam int unsigned MismatchReportMax = 10;
  localparam int unsigned LongHoldCycles    = 300;
  localparam int unsigned DrainCycles       = 8;

  typedef struct packed {
    entry_t     ent;
    logic [5:0] err;
    logic       busy;
    logic       mdone;
    logic       sdone;
    logic       last;
  } bus_action_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_ready_o;
  logic [1:0] opcode_i         = '0;
  logic [4:0] status_code_i    = '0;
  logic [7:0] tx_length_i      = '0;
  logic [7:0] rx_length_i      = '0;
  logic [7:0] target_address_i = '0;
  logic       lines_idle_i     = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i      = 1'b0;
  logic [3:0] action_o;
  logic [7:0] data_byte_o;
  logic [1:0] buffer_select_o;
  logic [7:0] buffer_index_o;
  logic [4:0] error_status_o;
  logic       error_generic_o;
  logic       busy_flag_o;
  logic       master_done_o;
  logic       slave_done_o;
  logic       last_o;

  i2c_transaction_sequencer_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .status_code_i   (status_code_i),
    .tx_length_i     (tx_length_i),
    .rx_length_i     (rx_length_i),
    .target_address_i(target_address_i),
    .lines_idle_i    (lines_idle_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .action_o        (action_o),
    .data_byte_o     (data_byte_o),
    .buffer_select_o (buffer_select_o),
    .buffer_index_o  (buffer_index_o),
    .error_status_o  (error_status_o),
    .error_generic_o (error_generic_o),
    .busy_flag_o     (busy_flag_o),
    .master_done_o   (master_done_o),
    .slave_done_o    (slave_done_o),
    .last_o          (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Sequencer state as the predictor sees it.
  logic       rx_mode_q   = 1'b0;
  logic       busy_q      = 1'b0;
  logic [7:0] addr_q      = '0;
  logic [7:0] mpos_q      = '0;
  logic [7:0] spos_q      = '0;
  logic [7:0] mtx_len_q   = '0;
  logic [7:0] mrx_len_q   = '0;
  logic [7:0] srx_cap_q   = '0;
  logic [7:0] stx_len_q   = '0;
  logic [5:0] err_q       = '0;

  bus_action_t expected_actions[$];
  int unsigned failures          = 0;
  int unsigned requests_sent     = 0;
  int unsigned cycle_count       = 0;
  int unsigned ready_stall       = 0;
  logic        idling_on         = 1'b1;
  logic        long_hold_pending = 1'b0;

  function automatic entry_t bus_step(action_e a, logic [7:0] data, logic [1:0] sel,
                                      logic [7:0] idx);
    entry_t e;
    e.act  = a;
    e.data = data;
    e.sel  = sel;
    e.idx  = idx;
    return e;
  endfunction

  function automatic logic master_waiting();
    return (mtx_len_q != 8'h00) || (mrx_len_q != 8'h00);
  endfunction

  // Applies one accepted request to the modelled state and queues the run of
  // actions the block should answer with.
  function automatic void predict_actions(req_t r);
    entry_t      run[$];
    bus_action_t e;
    logic        mdone;
    logic        sdone;
    logic [4:0]  s;
    mdone = 1'b0;
    sdone = 1'b0;
    s     = r.status_code;
    case (r.opcode)
      OP_STATUS: begin
        case (s)
          ST_START, ST_RSTART: begin
            mpos_q = '0;
            busy_q = 1'b1;
            run.push_back(bus_step(ACT_ADDRESS, {addr_q[7:1], rx_mode_q}, SEL_UNUSED, 8'h00));
          end
          ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
            if (mpos_q < mtx_len_q) begin
              run.push_back(bus_step(ACT_SEND, 8'h00, SEL_MASTER_TX, mpos_q));
              mpos_q = mpos_q + 8'd1;
            end else if (mrx_len_q != 8'h00) begin
              rx_mode_q = 1'b1;
              run.push_back(bus_step(ACT_START, 8'h00, SEL_UNUSED, 8'h00));
              mtx_len_q = '0;
            end else begin
              err_q = ERR_SUCCESS;
              run.push_back(bus_step(ACT_STOP, 8'h00, SEL_UNUSED, 8'h00));
              busy_q    = 1'b0;
              mtx_len_q = '0;
              mrx_len_q = '0;
              mdone     = 1'b1;
              if (srx_cap_q != 8'h00)
                run.push_back(bus_step(ACT_LISTEN, 8'h00, SEL_UNUSED, 8'h00));
            end
          end
          ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_ARB_LOST, ST_MR_SLA_NACK: begin
            err_q = {1'b0, s};
            run.push_back(bus_step(s == ST_ARB_LOST ? ACT_RELEASE : ACT_STOP, 8'h00,
                                   SEL_UNUSED, 8'h00));
            busy_q = 1'b0;
            run.push_back(bus_step(srx_cap_q != 8'h00 ? ACT_LISTEN : ACT_ENABLE, 8'h00,
                                   SEL_UNUSED, 8'h00));
            mtx_len_q = '0;
            mrx_len_q = '0;
            mdone     = 1'b1;
          end
          ST_MR_DATA_ACK, ST_MR_SLA_ACK: begin
            if (s == ST_MR_DATA_ACK && mpos_q < mrx_len_q) begin
              run.push_back(bus_step(ACT_STORE, 8'h00, SEL_MASTER_RX, mpos_q));
              mpos_q = mpos_q + 8'd1;
            end
            run.push_back(bus_step(int'(mpos_q) + 1 < int'(mrx_len_q) ? ACT_ACK : ACT_NACK,
                                   8'h00, SEL_UNUSED, 8'h00));
          end
          ST_MR_DATA_NACK: begin
            if (mpos_q < mrx_len_q)
              run.push_back(bus_step(ACT_STORE, 8'h00, SEL_MASTER_RX, mpos_q));
            err_q = {1'b0, s};
            run.push_back(bus_step(ACT_STOP, 8'h00, SEL_UNUSED, 8'h00));
            busy_q = 1'b0;
            run.push_back(bus_step(srx_cap_q != 8'h00 ? ACT_LISTEN : ACT_ENABLE, 8'h00,
                                   SEL_UNUSED, 8'h00));
            mtx_len_q = '0;
            mrx_len_q = '0;
            mdone     = 1'b1;
          end
          ST_SR_SLA_ACK, ST_SR_ARB_SLA, ST_SR_GC_ACK, ST_SR_ARB_GC: begin
            if (srx_cap_q != 8'h00) begin
              spos_q = '0;
              busy_q = 1'b1;
              run.push_back(bus_step(ACT_ACK, 8'h00, SEL_UNUSED, 8'h00));
            end else begin
              err_q = {1'b0, s};
              run.push_back(bus_step(ACT_NACK, 8'h00, SEL_UNUSED, 8'h00));
            end
          end
          ST_SR_DATA_ACK, ST_SR_DATA_NACK, ST_SR_GC_DATA_ACK, ST_SR_GC_DATA_NAK: begin
            if ((s == ST_SR_DATA_ACK || s == ST_SR_GC_DATA_ACK) && spos_q < srx_cap_q) begin
              run.push_back(bus_step(ACT_STORE, 8'h00, SEL_SLAVE_RX, spos_q));
              run.push_back(bus_step(int'(spos_q) + 1 < int'(srx_cap_q) ? ACT_ACK : ACT_NACK,
                                     8'h00, SEL_UNUSED, 8'h00));
              spos_q = spos_q + 8'd1;
            end else begin
              run.push_back(bus_step(master_waiting() ? ACT_START : ACT_NACK, 8'h00,
                                     SEL_UNUSED, 8'h00));
            end
          end
          ST_SR_STOP: begin
            err_q  = {1'b0, ST_SR_STOP};
            busy_q = 1'b0;
            run.push_back(bus_step(ACT_BLOCK, 8'h00, SEL_SLAVE_RX, spos_q));
            srx_cap_q = '0;
            sdone     = 1'b1;
          end
          ST_ST_SLA_ACK, ST_ST_ARB_SLA, ST_ST_DATA_ACK: begin
            if (s != ST_ST_DATA_ACK) begin
              spos_q = '0;
              busy_q = 1'b1;
            end
            if (spos_q < stx_len_q) begin
              run.push_back(bus_step(ACT_SEND, 8'h00, SEL_SLAVE_TX, spos_q));
              run.push_back(bus_step(int'(spos_q) + 1 < int'(stx_len_q) ? ACT_ACK : ACT_NACK,
                                     8'h00, SEL_UNUSED, 8'h00));
              spos_q = spos_q + 8'd1;
            end else begin
              run.push_back(bus_step(ACT_ZERO, 8'h00, SEL_UNUSED, 8'h00));
              run.push_back(bus_step(ACT_NACK, 8'h00, SEL_UNUSED, 8'h00));
            end
          end
          ST_ST_DATA_NACK, ST_ST_LAST_ACK: begin
            run.push_back(bus_step(ACT_ENABLE, 8'h00, SEL_UNUSED, 8'h00));
            err_q     = {1'b0, s};
            busy_q    = 1'b0;
            stx_len_q = '0;
            sdone     = 1'b1;
            if (master_waiting())
              run.push_back(bus_step(ACT_START, 8'h00, SEL_UNUSED, 8'h00));
          end
          default: begin
            // Bus error, no information or an unknown code: drop everything.
            err_q     = ERR_GENERIC;
            spos_q    = '0;
            mpos_q    = '0;
            mtx_len_q = '0;
            mrx_len_q = '0;
            srx_cap_q = '0;
            stx_len_q = '0;
            run.push_back(bus_step(ACT_RELEASE, 8'h00, SEL_UNUSED, 8'h00));
            busy_q = 1'b0;
            mdone  = 1'b1;
            sdone  = 1'b1;
          end
        endcase
      end
      OP_MASTER: begin
        if (r.tx_length == 8'h00 && r.rx_length == 8'h00) begin
          mtx_len_q = '0;
          mrx_len_q = '0;
        end else begin
          mtx_len_q = r.tx_length;
          mrx_len_q = r.rx_length;
          addr_q    = r.target_address;
          rx_mode_q = (r.tx_length == 8'h00);
          if (!busy_q && r.lines_idle)
            run.push_back(bus_step(ACT_START, 8'h00, SEL_UNUSED, 8'h00));
        end
      end
      OP_LISTEN: begin
        srx_cap_q = r.rx_length;
        if (!busy_q)
          run.push_back(bus_step(master_waiting() && r.lines_idle ? ACT_START : ACT_LISTEN,
                                 8'h00, SEL_UNUSED, 8'h00));
      end
      default: begin
        if (r.tx_length != 8'h00) begin
          spos_q    = '0;
          stx_len_q = r.tx_length;
          run.push_back(bus_step(ACT_LISTEN, 8'h00, SEL_UNUSED, 8'h00));
        end else if (master_waiting()) begin
          run.push_back(bus_step(ACT_START, 8'h00, SEL_UNUSED, 8'h00));
        end else begin
          busy_q = 1'b0;
          run.push_back(bus_step(ACT_ENABLE, 8'h00, SEL_UNUSED, 8'h00));
        end
      end
    endcase
    foreach (run[k]) begin
      e.ent   = run[k];
      e.err   = err_q;
      e.busy  = busy_q;
      e.mdone = mdone;
      e.sdone = sdone;
      e.last  = (k == run.size() - 1);
      expected_actions.push_back(e);
    end
  endfunction

  function automatic string describe(bus_action_t a);
    return $sformatf("act=%0d data=%h sel=%0d idx=%0d err=%h busy=%b md=%b sd=%b last=%b",
                     a.ent.act, a.ent.data, a.ent.sel, a.ent.idx, a.err, a.busy, a.mdone,
                     a.sdone, a.last);
  endfunction

  function automatic void note_failure(string what);
    failures++;
    if (failures <= MismatchReportMax)
      $display("%s", what);
  endfunction

  function automatic int unsigned random_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    else if (roll < 88)
      return $urandom_range(1, 3);
    else if (roll < 97)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 60);
  endfunction

  // Requests are predicted before results are checked, so the order of the
  // two within one edge never matters.
  always @(posedge clk_i) begin : check_results
    req_t        req;
    bus_action_t seen;
    bus_action_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        req.opcode         = opcode_e'(opcode_i);
        req.status_code    = status_code_i;
        req.tx_length      = tx_length_i;
        req.rx_length      = rx_length_i;
        req.target_address = target_address_i;
        req.lines_idle     = lines_idle_i;
        predict_actions(req);
      end
      if (out_valid_o && out_ready_i) begin
        seen.ent.act  = action_e'(action_o);
        seen.ent.data = data_byte_o;
        seen.ent.sel  = buffer_select_o;
        seen.ent.idx  = buffer_index_o;
        seen.err      = {error_generic_o, error_status_o};
        seen.busy     = busy_flag_o;
        seen.mdone    = master_done_o;
        seen.sdone    = slave_done_o;
        seen.last     = last_o;
        if (expected_actions.size() == 0) begin
          note_failure({"unexpected action: ", describe(seen)});
        end else begin
          want = expected_actions.pop_front();
          if (seen.ent.act !== want.ent.act || seen.ent.data !== want.ent.data ||
              seen.ent.sel !== want.ent.sel || seen.ent.idx !== want.ent.idx ||
              seen.err !== want.err || seen.busy !== want.busy ||
              seen.mdone !== want.mdone || seen.sdone !== want.sdone ||
              seen.last !== want.last)
            note_failure({"action mismatch: expected ", describe(want), " got ",
                          describe(seen)});
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        ready_stall       = LongHoldCycles;
      end
      if (ready_stall > 0) begin
        ready_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (idling_on && $urandom_range(0, 3) == 0)
          ready_stall = random_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[i2c_transaction_sequencer_top] ERROR");
      $finish;
    end
  end

  // Offers one request and returns at the edge where it is taken. Valid is
  // left high so that a following request can go out back to back.
  task automatic send_request(input opcode_e op, input logic [4:0] status,
                              input logic [7:0] tx_len, input logic [7:0] rx_len,
                              input logic [7:0] addr, input logic idle);
    int unsigned gap;
    gap = idling_on ? random_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    status_code_i    <= status;
    tx_length_i      <= tx_len;
    rx_length_i      <= rx_len;
    target_address_i <= addr;
    lines_idle_i     <= idle;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
  endtask

  task automatic send_status(input logic [4:0] status);
    send_request(OP_STATUS, status, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_command(input opcode_e op, input logic [7:0] tx_len,
                              input logic [7:0] rx_len, input logic [7:0] addr,
                              input logic idle);
    send_request(op, 5'($urandom_range(0, 31)), tx_len, rx_len, addr, idle);
  endtask

  task automatic send_noise();
    send_request(opcode_e'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                 $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255)),
                 $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_actions.size() != 0);
  endtask

  // Now and then a status event in a well-formed sequence is swapped for an
  // arbitrary one, so that transfers also end in faults part way through.
  function automatic logic [4:0] disturb(logic [4:0] status);
    if ($urandom_range(0, 39) != 0)
      return status;
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70)
      return $urandom_range(1, 4);
    else if (roll < 95)
      return $urandom_range(5, 12);
    else
      return $urandom_range(13, 40);
  endfunction

  task automatic run_master_transfer(input int unsigned tx_len, input int unsigned rx_len);
    send_command(OP_MASTER, 8'(tx_len), 8'(rx_len), 8'($urandom_range(0, 255)),
                 $urandom_range(0, 7) != 0);
    send_status(disturb(ST_START));
    if (tx_len != 0) begin
      send_status(disturb(ST_MT_SLA_ACK));
      repeat (tx_len) send_status(disturb(ST_MT_DATA_ACK));
      if (rx_len != 0)
        send_status(disturb(ST_RSTART));
    end
    if (rx_len != 0) begin
      send_status(disturb(ST_MR_SLA_ACK));
      repeat (rx_len - 1) send_status(disturb(ST_MR_DATA_ACK));
      send_status(disturb(ST_MR_DATA_NACK));
    end
  endtask

  task automatic run_slave_receive(input int unsigned capacity);
    send_command(OP_LISTEN, 8'($urandom_range(0, 255)), 8'(capacity),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_status(disturb(ST_SR_SLA_ACK + 5'($urandom_range(0, 3))));
    repeat ($urandom_range(0, capacity + 1))
      send_status(disturb($urandom_range(0, 1) ? ST_SR_DATA_ACK : ST_SR_GC_DATA_ACK));
    if ($urandom_range(0, 3) == 0)
      send_status(disturb($urandom_range(0, 1) ? ST_SR_DATA_NACK : ST_SR_GC_DATA_NAK));
    send_status(disturb(ST_SR_STOP));
  endtask

  task automatic run_slave_transmit(input int unsigned tx_len);
    send_command(OP_RESPOND, 8'(tx_len), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_status(disturb($urandom_range(0, 1) ? ST_ST_SLA_ACK : ST_ST_ARB_SLA));
    repeat ($urandom_range(tx_len > 1 ? tx_len - 2 : 0, tx_len))
      send_status(disturb(ST_ST_DATA_ACK));
    send_status(disturb($urandom_range(0, 1) ? ST_ST_DATA_NACK : ST_ST_LAST_ACK));
  endtask

  // Write then read with a repeated start, then a stray data ack with
  // nothing pending, which is answered with a stop.
  task automatic test_master_transfer();
    send_command(OP_MASTER, 8'd1, 8'd1, 8'hA5, 1'b1);
    send_status(ST_START);
    send_status(ST_MT_SLA_ACK);
    send_status(ST_MT_DATA_ACK);
    send_status(ST_RSTART);
    send_status(ST_MR_SLA_ACK);
    send_status(ST_MR_DATA_NACK);
    send_status(ST_MT_DATA_ACK);
    wait_drained();
  endtask

  // A master request on busy lines is only stored; a later listen starts it.
  task automatic test_deferred_requests();
    send_command(OP_MASTER, 8'hFF, 8'hFF, 8'h00, 1'b0);
    send_command(OP_LISTEN, 8'h00, 8'hFF, 8'hFF, 1'b1);
    send_command(OP_MASTER, 8'h00, 8'h00, 8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_slave_receive();
    send_command(OP_LISTEN, 8'hFF, 8'd1, 8'h5A, 1'b0);
    send_status(ST_SR_SLA_ACK);
    send_status(ST_SR_DATA_ACK);
    send_status(ST_SR_GC_DATA_NAK);
    send_status(ST_SR_STOP);
    send_status(ST_SR_GC_ACK);
    wait_drained();
  endtask

  task automatic test_slave_transmit();
    send_command(OP_RESPOND, 8'd1, 8'hFF, 8'h00, 1'b1);
    send_status(ST_ST_SLA_ACK);
    send_status(ST_ST_DATA_ACK);
    send_status(ST_ST_LAST_ACK);
    send_command(OP_RESPOND, 8'h00, 8'h00, 8'hFF, 1'b0);
    wait_drained();
  endtask

  task automatic test_bus_faults();
    send_status(ST_ARB_LOST);
    send_status(ST_BUS_ERROR);
    send_status(ST_NO_INFO);
    wait_drained();
  endtask

  // The receiver holds off while requests keep coming back to back, so the
  // block fills up and has to stall its request side.
  task automatic test_back_pressure();
    idling_on         = 1'b0;
    long_hold_pending = 1'b1;
    repeat (24) send_noise();
    idling_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    int unsigned tx_len;
    target = requests_sent + RandomRequests;
    while (requests_sent < target) begin
      idling_on = ($urandom_range(0, 4) != 0);
      tx_len    = pick_length();
      case ($urandom_range(0, 9))
        0, 1:    run_master_transfer(tx_len, 0);
        2:       run_master_transfer(0, pick_length());
        3:       run_master_transfer(tx_len, pick_length());
        4, 5:    run_slave_receive(tx_len);
        6, 7:    run_slave_transmit(tx_len);
        default: repeat ($urandom_range(1, 3)) send_noise();
      endcase
      if ($urandom_range(0, 15) == 0)
        wait_drained();
    end
    idling_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_master_transfer();
    test_deferred_requests();
    test_slave_receive();
    test_slave_transmit();
    test_bus_faults();
    test_back_pressure();
    test_random_traffic();
    repeat (DrainCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("[i2c_transaction_sequencer_top] OK");
    end else begin
      $display("[i2c_transaction_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule
